>>> rtl/orrq_pkg.sv
// shared types, constants and helpers for the overwrite ring record queue
`default_nettype none

package orrq_pkg;

  localparam int unsigned MAX_SLOTS        = 16;
  localparam int unsigned MAX_RECORD_BYTES = 8;

  localparam int unsigned SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_OVR = 3'd0,
    ACT_PUSH_CHK = 3'd1,
    ACT_POP      = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_PEEK     = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_BYTES = 2'd0,
    CFG_QUEUE_CAP   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [DATA_W-1:0] entry_data;
    logic [7:0]        entry_length;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               dropped_oldest;
    logic [DATA_W-1:0]  front_data;
    logic [LEN_W-1:0]   front_length;
    logic [COUNT_W-1:0] occupancy;
    logic               is_empty;
  } rsp_t;

  // effective configuration seen by the queue core
  typedef struct packed {
    logic [LEN_W-1:0]   entry_bytes;
    logic [COUNT_W-1:0] capacity;
    logic               clear;
  } cfg_t;

  // ones in every byte below n
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (n > LEN_W'(i)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/orrq_cfg.sv
// configuration registers with clamping to legal values
`default_nettype none

module orrq_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [orrq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [orrq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output orrq_pkg::cfg_t                        cfg_o
);

  logic [orrq_pkg::LEN_W-1:0]   entry_q, entry_d;
  logic [orrq_pkg::COUNT_W-1:0] cap_q, cap_d;
  logic                         hit;

  always_comb begin
    entry_d = entry_q;
    cap_d   = cap_q;
    hit     = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        orrq_pkg::CFG_ENTRY_BYTES: begin
          entry_d = cfg_data_i[orrq_pkg::LEN_W-1:0];
          hit     = 1'b1;
        end
        orrq_pkg::CFG_QUEUE_CAP: begin
          cap_d = cfg_data_i[orrq_pkg::COUNT_W-1:0];
          hit   = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= orrq_pkg::LEN_W'(orrq_pkg::MAX_RECORD_BYTES);
      cap_q   <= orrq_pkg::COUNT_W'(orrq_pkg::MAX_SLOTS);
    end else begin
      entry_q <= entry_d;
      cap_q   <= cap_d;
    end
  end

  // zero acts as one, oversize acts as the built maximum
  always_comb begin
    if (entry_q == '0) begin
      cfg_o.entry_bytes = orrq_pkg::LEN_W'(1);
    end else if (entry_q > orrq_pkg::LEN_W'(orrq_pkg::MAX_RECORD_BYTES)) begin
      cfg_o.entry_bytes = orrq_pkg::LEN_W'(orrq_pkg::MAX_RECORD_BYTES);
    end else begin
      cfg_o.entry_bytes = entry_q;
    end
    if (cap_q == '0) begin
      cfg_o.capacity = orrq_pkg::COUNT_W'(1);
    end else if (cap_q > orrq_pkg::COUNT_W'(orrq_pkg::MAX_SLOTS)) begin
      cfg_o.capacity = orrq_pkg::COUNT_W'(orrq_pkg::MAX_SLOTS);
    end else begin
      cfg_o.capacity = cap_q;
    end
    cfg_o.clear = hit;
  end

endmodule

`default_nettype wire

>>> rtl/orrq_core.sv
// queue state, slot storage and per-word result logic
`default_nettype none

module orrq_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire orrq_pkg::cfg_t cfg_i,
  input  wire logic           valid_i,
  input  wire orrq_pkg::req_t req_i,
  output orrq_pkg::rsp_t      rsp_o
);

  localparam int unsigned IW = orrq_pkg::SLOT_IDX_W;
  localparam int unsigned CW = orrq_pkg::COUNT_W;
  localparam int unsigned LW = orrq_pkg::LEN_W;
  localparam int unsigned DW = orrq_pkg::DATA_W;

  logic [DW-1:0] slot_data_q [orrq_pkg::MAX_SLOTS];
  logic [LW-1:0] slot_len_q  [orrq_pkg::MAX_SLOTS];

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  logic          full;
  logic [CW-1:0] head_inc;
  logic [IW-1:0] head_next;
  logic [CW-1:0] tail_sum;
  logic [CW-1:0] tail_wrap;
  logic [IW-1:0] tail;
  logic [LW-1:0] len_c;
  logic [DW-1:0] wr_data;
  logic          wr_en;
  logic          accepted;
  logic          dropped;

  assign full      = count_q >= cfg_i.capacity;
  assign head_inc  = CW'(head_q) + CW'(1);
  assign head_next = (head_inc >= cfg_i.capacity) ? '0 : head_inc[IW-1:0];
  assign tail_sum  = CW'(head_q) + count_q;
  assign tail_wrap = (tail_sum >= cfg_i.capacity) ? tail_sum - cfg_i.capacity : tail_sum;
  assign tail      = tail_wrap[IW-1:0];
  assign len_c     = (req_i.entry_length > 8'(cfg_i.entry_bytes)) ? cfg_i.entry_bytes
                                                                   : req_i.entry_length[LW-1:0];
  assign wr_data   = req_i.entry_data & orrq_pkg::byte_mask(len_c);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    accepted = 1'b0;
    dropped  = 1'b0;
    case (req_i.action)
      orrq_pkg::ACT_PUSH_OVR, orrq_pkg::ACT_PUSH_CHK: begin
        if (!(req_i.action == orrq_pkg::ACT_PUSH_CHK && full)) begin
          wr_en    = valid_i;
          accepted = 1'b1;
          if (full) begin
            head_d  = head_next;
            dropped = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
      end
      orrq_pkg::ACT_POP: begin
        if (count_q != '0) begin
          head_d  = head_next;
          count_d = count_q - CW'(1);
        end
      end
      orrq_pkg::ACT_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cfg_i.clear) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (valid_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // slots keep already masked bytes
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_data_q[tail] <= wr_data;
      slot_len_q[tail]  <= len_c;
    end
  end

  // front after the step, with bypass of this step's write
  always_comb begin
    rsp_o.accepted       = accepted;
    rsp_o.dropped_oldest = dropped;
    rsp_o.occupancy      = count_d;
    rsp_o.is_empty       = (count_d == '0);
    if (count_d == '0) begin
      rsp_o.front_data   = '0;
      rsp_o.front_length = '0;
    end else if (wr_en && tail == head_d) begin
      rsp_o.front_data   = wr_data;
      rsp_o.front_length = len_c;
    end else begin
      rsp_o.front_data   = slot_data_q[head_d];
      rsp_o.front_length = slot_len_q[head_d];
    end
  end

endmodule

`default_nettype wire

>>> rtl/overwrite_ring_record_queue_core.sv
// top level of the overwrite ring record queue
`default_nettype none

// Circular queue of up to 16 records of up to 8 bytes each. A command word is
// taken on any cycle with start_i high; busy_o stays low, so a new word can be
// issued every clock. Each word gives exactly one result, shown on rsp_o for a
// single cycle with done_o high, after passing first the command register
// and then the result register. The result cannot be stalled, so capture it
// when done_o is high. Head, count and the slot write are all updated in the
// same cycle from the command register, so back to back commands see each
// other's effect in order. A write to either configuration register also
// empties the queue; write only while no command is in flight. cfg_ready_o
// is always high.

module overwrite_ring_record_queue_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output wire logic                             busy_o,
  input  wire orrq_pkg::req_t                   req_i,
  output wire logic                             done_o,
  output orrq_pkg::rsp_t                        rsp_o,
  input  wire logic                             cfg_valid_i,
  output wire logic                             cfg_ready_o,
  input  wire logic [orrq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [orrq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  orrq_pkg::cfg_t cfg;
  orrq_pkg::req_t req_q;
  orrq_pkg::rsp_t rsp_d, rsp_q;
  logic           valid_q;
  logic           done_q;
  logic           take;

  // one word per cycle, never held off
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start_i && !busy_o;

  orrq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
    end
  end

  orrq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (valid_q),
    .req_i   (req_q),
    .rsp_o   (rsp_d)
  );

  // result register, strobed for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every taken word yields its result strobe after the command and result registers
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ##1 done_o)
    else $error("missing result strobe");

  // a dropped record only comes with a stored push
  a_drop_implies_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.dropped_oldest) |-> rsp_o.accepted)
    else $error("drop without accept");

  // empty flag agrees with occupancy, and an empty queue shows no front
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.occupancy == '0)) &&
               (!rsp_o.is_empty || (rsp_o.front_length == '0 && rsp_o.front_data == '0)))
    else $error("empty result inconsistent");

  // occupancy never exceeds the built depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.occupancy <= orrq_pkg::COUNT_W'(orrq_pkg::MAX_SLOTS))
    else $error("occupancy above depth");

endmodule

`default_nettype wire
